>>> hw/rtl/mhtq_pkg.sv
package mhtq_pkg;

    // Field widths fixed by the request and result formats.
    localparam int ACTION_W = 2;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    // Defaults for the top level parameters.
    localparam int CAPACITY_DEF  = 64;
    localparam int ID_BITS_DEF   = 16;
    localparam int TIME_BITS_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_POP    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FIRED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_NONE_DUE  = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS,
        S_IU_CHK,
        S_IU_CMP,
        S_TK_RD,
        S_TK_CMP,
        S_TK_END,
        S_CN_RD,
        S_CN_CHK,
        S_POP,
        S_POP_RD,
        S_RM_START,
        S_RM_LAST,
        S_SD_CHK,
        S_SD_L,
        S_SD_R,
        S_SD_CMP,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/min_heap_timer_queue.sv
// The sequencer makes at most one heap store access per cycle and uses the one shared compare
// unit; a held result stalls it.
// Throughput: one request at a time; the next is taken once the sequencer is idle.
// Reset (synchronous, active low) empties the queue and drops any result held for output.
module min_heap_timer_queue #(
    parameter int CAPACITY  = mhtq_pkg::CAPACITY_DEF,
    parameter int ID_BITS   = mhtq_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = mhtq_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mhtq_pkg::ACTION_W-1:0] i_action,
    input  logic [mhtq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [mhtq_pkg::TIME_W-1:0]   i_expire_time,
    input  logic [mhtq_pkg::TIME_W-1:0]   i_now,
    // Result channel.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mhtq_pkg::STATUS_W-1:0] o_status,
    output logic [mhtq_pkg::ID_W-1:0]     o_result_id,
    output logic                          o_last
);

    // Address width of the heap store and width of the entry count.
    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    // Child index 2*pos+2 can reach 2*CAPACITY, so it gets two extra bits.
    localparam int CXW = AW + 2;
    // A heap entry is {expiry, id, cancelled}.
    localparam int ENTRY_W = TIME_BITS + ID_BITS + 1;
    // Widths wide enough for both a port field and the internal field.
    localparam int IDX_W = (ID_BITS > mhtq_pkg::ID_W) ? ID_BITS : mhtq_pkg::ID_W;
    localparam int TX_W  = (TIME_BITS > mhtq_pkg::TIME_W) ? TIME_BITS : mhtq_pkg::TIME_W;

    mhtq_pkg::t_state  r_state;
    mhtq_pkg::t_state  n_state;
    mhtq_pkg::t_action r_op;

    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_cidx;
    logic [CW-1:0]        r_idx;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_time;
    logic [ENTRY_W-1:0]   r_mov;
    logic [ENTRY_W-1:0]   r_child;
    logic [ENTRY_W-1:0]   r_rd_data;
    logic                 r_found;
    logic                 r_pend_valid;
    logic [ID_BITS-1:0]   r_pend_id;
    mhtq_pkg::t_status    r_fin_status;
    logic [ID_BITS-1:0]   r_fin_id;

    // Output register.
    logic                          r_out_valid;
    logic [mhtq_pkg::STATUS_W-1:0] r_out_status;
    logic [mhtq_pkg::ID_W-1:0]     r_out_id;
    logic                          r_out_last;

    // Heap store: one write port and one registered read port.
    logic [ENTRY_W-1:0] mem [CAPACITY];

    logic               w_re;
    logic [AW-1:0]      w_rd_addr;
    logic               w_we;
    logic [AW-1:0]      w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;

    // Fields of the last entry read.
    logic [TIME_BITS-1:0] w_rd_exp;
    logic [ID_BITS-1:0]   w_rd_id;
    logic                 w_rd_canc;

    // Request fields narrowed or widened to the internal widths.
    logic [IDX_W-1:0]     w_in_id_ext;
    logic [TX_W-1:0]      w_in_exp_ext;
    logic [TX_W-1:0]      w_in_now_ext;
    logic [TIME_BITS-1:0] w_in_time;

    // Heap index arithmetic.
    logic [CXW-1:0] w_c;
    logic [CXW-1:0] w_c1;
    logic [CXW-1:0] w_count_x;
    logic           w_has_left;
    logic           w_has_right;
    logic [AW-1:0]  w_par;

    // The one shared magnitude comparator: w_gt = a > b.
    logic [TIME_BITS-1:0] w_cmp_a;
    logic [TIME_BITS-1:0] w_cmp_b;
    logic                 w_gt;

    logic               w_accept;
    logic               w_out_free;
    logic               w_emit;
    mhtq_pkg::t_status  w_emit_status;
    logic [ID_BITS-1:0] w_emit_id;
    logic [IDX_W-1:0]   w_emit_id_ext;
    logic               w_emit_last;
    logic               w_tk_due;
    logic               w_tk_stall;
    logic               w_id_match;
    logic [ENTRY_W-1:0] w_new_entry;
    mhtq_pkg::t_state   w_rm_ret;

    assign w_rd_exp  = r_rd_data[ENTRY_W-1 -: TIME_BITS];
    assign w_rd_id   = r_rd_data[ID_BITS:1];
    assign w_rd_canc = r_rd_data[0];

    assign w_in_id_ext  = IDX_W'(i_timer_id);
    assign w_in_exp_ext = TX_W'(i_expire_time);
    assign w_in_now_ext = TX_W'(i_now);
    assign w_in_time = (mhtq_pkg::t_action'(i_action) == mhtq_pkg::ACT_TICK)
                     ? w_in_now_ext[TIME_BITS-1:0] : w_in_exp_ext[TIME_BITS-1:0];

    assign w_c         = CXW'({r_pos, 1'b1});
    assign w_c1        = w_c + CXW'(1);
    assign w_count_x   = CXW'(r_count);
    assign w_has_left  = (w_c < w_count_x);
    assign w_has_right = (w_c1 < w_count_x);
    assign w_par       = AW'((r_pos - AW'(1)) >> 1);

    assign w_gt = (w_cmp_a > w_cmp_b);

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_tk_due   = !w_gt;
    assign w_tk_stall = w_tk_due && !w_rd_canc && r_pend_valid && !w_out_free;
    assign w_id_match = (w_rd_id == r_id);
    assign w_new_entry = {r_time, r_id, 1'b0};
    // After a root removal a tick looks at the new root; a pop reports.
    assign w_rm_ret = (r_op == mhtq_pkg::ACT_TICK) ? mhtq_pkg::S_TK_RD : mhtq_pkg::S_DONE;

    assign o_ready = (r_state == mhtq_pkg::S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mhtq_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (mhtq_pkg::t_action'(i_action))
                        mhtq_pkg::ACT_INSERT: n_state = mhtq_pkg::S_INS;
                        mhtq_pkg::ACT_TICK:   n_state = mhtq_pkg::S_TK_RD;
                        mhtq_pkg::ACT_CANCEL: n_state = mhtq_pkg::S_CN_RD;
                        mhtq_pkg::ACT_POP:    n_state = mhtq_pkg::S_POP;
                        default:              n_state = mhtq_pkg::S_IDLE;
                    endcase
                end
            end
            mhtq_pkg::S_INS: begin
                n_state = (r_count >= CW'(CAPACITY)) ? mhtq_pkg::S_DONE : mhtq_pkg::S_IU_CHK;
            end
            mhtq_pkg::S_IU_CHK: begin
                n_state = (r_pos == '0) ? mhtq_pkg::S_DONE : mhtq_pkg::S_IU_CMP;
            end
            mhtq_pkg::S_IU_CMP: begin
                n_state = w_gt ? mhtq_pkg::S_IU_CHK : mhtq_pkg::S_DONE;
            end
            mhtq_pkg::S_TK_RD: begin
                n_state = (r_count == '0) ? mhtq_pkg::S_TK_END : mhtq_pkg::S_TK_CMP;
            end
            mhtq_pkg::S_TK_CMP: begin
                if (!w_tk_due) begin
                    n_state = mhtq_pkg::S_TK_END;
                end else if (!w_tk_stall) begin
                    n_state = mhtq_pkg::S_RM_START;
                end
            end
            mhtq_pkg::S_TK_END: n_state = mhtq_pkg::S_DONE;
            mhtq_pkg::S_CN_RD: begin
                n_state = (r_idx < r_count) ? mhtq_pkg::S_CN_CHK : mhtq_pkg::S_DONE;
            end
            mhtq_pkg::S_CN_CHK: n_state = mhtq_pkg::S_CN_RD;
            mhtq_pkg::S_POP: begin
                n_state = (r_count == '0) ? mhtq_pkg::S_DONE : mhtq_pkg::S_POP_RD;
            end
            mhtq_pkg::S_POP_RD: n_state = mhtq_pkg::S_RM_START;
            mhtq_pkg::S_RM_START: begin
                n_state = (r_count == CW'(1)) ? w_rm_ret : mhtq_pkg::S_RM_LAST;
            end
            mhtq_pkg::S_RM_LAST: n_state = mhtq_pkg::S_SD_CHK;
            mhtq_pkg::S_SD_CHK: begin
                n_state = w_has_left ? mhtq_pkg::S_SD_L : w_rm_ret;
            end
            mhtq_pkg::S_SD_L: begin
                n_state = w_has_right ? mhtq_pkg::S_SD_R : mhtq_pkg::S_SD_CMP;
            end
            mhtq_pkg::S_SD_R: n_state = mhtq_pkg::S_SD_CMP;
            mhtq_pkg::S_SD_CMP: begin
                n_state = w_gt ? mhtq_pkg::S_SD_CHK : w_rm_ret;
            end
            mhtq_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = mhtq_pkg::S_IDLE;
                end
            end
            default: n_state = mhtq_pkg::S_IDLE;
        endcase
    end

    // Memory ports, comparator operands and result emission.
    always_comb begin
        w_re          = 1'b0;
        w_rd_addr     = '0;
        w_we          = 1'b0;
        w_wr_addr     = r_pos;
        w_wr_data     = w_new_entry;
        w_cmp_a       = w_rd_exp;
        w_cmp_b       = r_time;
        w_emit        = 1'b0;
        w_emit_status = r_fin_status;
        w_emit_id     = r_fin_id;
        w_emit_last   = 1'b1;
        unique case (r_state)
            mhtq_pkg::S_IU_CHK: begin
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end else begin
                    w_re      = 1'b1;
                    w_rd_addr = w_par;
                end
            end
            mhtq_pkg::S_IU_CMP: begin
                // Parent later than the new timer moves down one level.
                w_we      = 1'b1;
                w_wr_data = w_gt ? r_rd_data : w_new_entry;
            end
            mhtq_pkg::S_TK_RD, mhtq_pkg::S_POP: begin
                w_re      = (r_count != '0);
                w_rd_addr = '0;
            end
            mhtq_pkg::S_TK_CMP: begin
                // A newer live expiry pushes out the one held back.
                if (w_tk_due && !w_rd_canc && r_pend_valid && w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_status = mhtq_pkg::ST_FIRED;
                    w_emit_id     = r_pend_id;
                    w_emit_last   = 1'b0;
                end
            end
            mhtq_pkg::S_CN_RD: begin
                w_re      = (r_idx < r_count);
                w_rd_addr = r_idx[AW-1:0];
            end
            mhtq_pkg::S_CN_CHK: begin
                w_we      = w_id_match;
                w_wr_addr = AW'(r_idx);
                w_wr_data = {r_rd_data[ENTRY_W-1:1], 1'b1};
            end
            mhtq_pkg::S_RM_START: begin
                w_re      = (r_count != CW'(1));
                w_rd_addr = AW'(r_count - CW'(1));
            end
            mhtq_pkg::S_SD_CHK: begin
                if (w_has_left) begin
                    w_re      = 1'b1;
                    w_rd_addr = w_c[AW-1:0];
                end else begin
                    w_we      = 1'b1;
                    w_wr_data = r_mov;
                end
            end
            mhtq_pkg::S_SD_L: begin
                w_re      = w_has_right;
                w_rd_addr = w_c1[AW-1:0];
            end
            mhtq_pkg::S_SD_R: begin
                w_cmp_a = r_child[ENTRY_W-1 -: TIME_BITS];
                w_cmp_b = w_rd_exp;
            end
            mhtq_pkg::S_SD_CMP: begin
                w_cmp_a   = r_mov[ENTRY_W-1 -: TIME_BITS];
                w_cmp_b   = r_child[ENTRY_W-1 -: TIME_BITS];
                w_we      = 1'b1;
                w_wr_data = w_gt ? r_child : r_mov;
            end
            mhtq_pkg::S_DONE: begin
                w_emit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    assign w_emit_id_ext = IDX_W'(w_emit_id);

    // Heap store.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_re) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhtq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mhtq_pkg::S_INS && r_count < CW'(CAPACITY)) begin
                r_count <= r_count + CW'(1);
            end else if (r_state == mhtq_pkg::S_RM_START) begin
                r_count <= r_count - CW'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= w_emit_status;
            r_out_id     <= w_emit_id_ext[mhtq_pkg::ID_W-1:0];
            r_out_last   <= w_emit_last;
        end
        unique case (r_state)
            mhtq_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_op         <= mhtq_pkg::t_action'(i_action);
                    r_id         <= w_in_id_ext[ID_BITS-1:0];
                    r_time       <= w_in_time;
                    r_idx        <= '0;
                    r_found      <= 1'b0;
                    r_pend_valid <= 1'b0;
                    r_fin_id     <= '0;
                end
            end
            mhtq_pkg::S_INS: begin
                if (r_count >= CW'(CAPACITY)) begin
                    r_fin_status <= mhtq_pkg::ST_FULL;
                end else begin
                    r_pos <= AW'(r_count);
                end
            end
            mhtq_pkg::S_IU_CHK: begin
                r_fin_status <= mhtq_pkg::ST_OK;
            end
            mhtq_pkg::S_IU_CMP: begin
                if (w_gt) begin
                    r_pos <= w_par;
                end
            end
            mhtq_pkg::S_TK_CMP: begin
                if (w_tk_due && !w_tk_stall && !w_rd_canc) begin
                    r_pend_valid <= 1'b1;
                    r_pend_id    <= w_rd_id;
                end
            end
            mhtq_pkg::S_TK_END: begin
                if (r_pend_valid) begin
                    r_fin_status <= mhtq_pkg::ST_FIRED;
                    r_fin_id     <= r_pend_id;
                end else begin
                    r_fin_status <= mhtq_pkg::ST_NONE_DUE;
                end
            end
            mhtq_pkg::S_CN_RD: begin
                r_fin_status <= r_found ? mhtq_pkg::ST_OK : mhtq_pkg::ST_NOT_FOUND;
            end
            mhtq_pkg::S_CN_CHK: begin
                r_found <= r_found || w_id_match;
                r_idx   <= r_idx + CW'(1);
            end
            mhtq_pkg::S_POP: begin
                r_fin_status <= (r_count == '0) ? mhtq_pkg::ST_EMPTY : mhtq_pkg::ST_OK;
            end
            mhtq_pkg::S_POP_RD: begin
                r_fin_id <= w_rd_id;
            end
            mhtq_pkg::S_RM_LAST: begin
                // The last entry becomes the hole at the root and sifts down.
                r_mov <= r_rd_data;
                r_pos <= '0;
            end
            mhtq_pkg::S_SD_L: begin
                r_child <= r_rd_data;
                r_cidx  <= w_c[AW-1:0];
            end
            mhtq_pkg::S_SD_R: begin
                // Ties keep the left child.
                if (w_gt) begin
                    r_child <= r_rd_data;
                    r_cidx  <= w_c1[AW-1:0];
                end
            end
            mhtq_pkg::S_SD_CMP: begin
                if (w_gt) begin
                    r_pos <= r_cidx;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_result_id = r_out_id;
    assign o_last      = r_out_last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int HEAP_DEPTH     = mhtq_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 286;
    // Cycles without any accepted request or result before the run is declared hung.
    // The longest legal gap is the receiver hold-off.
    localparam int WATCHDOG_LIMIT = 20000;
    // A cancel scans the whole store, one entry after another.
    localparam int DRAIN_CYCLES   = 4 * HEAP_DEPTH + 50;
    localparam int HOLD_CYCLES    = 400;

    // One expected result word as it leaves the result channel.
    typedef struct {
        mhtq_pkg::t_status           status;
        logic [mhtq_pkg::ID_W-1:0]   id;
        logic                        last;
    } t_result_word;

    // One row of the directed stimulus table. Rows with has_want set carry their
    // expected single result typed in; all other rows are checked by the heap model.
    typedef struct {
        mhtq_pkg::t_action           act;
        logic [mhtq_pkg::ID_W-1:0]   id;
        logic [mhtq_pkg::TIME_W-1:0] expiry;
        logic [mhtq_pkg::TIME_W-1:0] now;
        bit                          has_want;
        mhtq_pkg::t_status           want_status;
        logic [mhtq_pkg::ID_W-1:0]   want_id;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [mhtq_pkg::ACTION_W-1:0] i_action;
    logic [mhtq_pkg::ID_W-1:0]     i_timer_id;
    logic [mhtq_pkg::TIME_W-1:0]   i_expire_time;
    logic [mhtq_pkg::TIME_W-1:0]   i_now;
    logic                          o_valid;
    logic                          i_ready;
    logic [mhtq_pkg::STATUS_W-1:0] o_status;
    logic [mhtq_pkg::ID_W-1:0]     o_result_id;
    logic                          o_last;

    min_heap_timer_queue #(
        .CAPACITY  (mhtq_pkg::CAPACITY_DEF),
        .ID_BITS   (mhtq_pkg::ID_BITS_DEF),
        .TIME_BITS (mhtq_pkg::TIME_BITS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_timer_id    (i_timer_id),
        .i_expire_time (i_expire_time),
        .i_now         (i_now),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_result_id   (o_result_id),
        .o_last        (o_last)
    );

    // Shadow copy of the timer heap, kept in step with every accepted request.
    logic [mhtq_pkg::TIME_W-1:0] shadow_expiry [HEAP_DEPTH];
    logic [mhtq_pkg::ID_W-1:0]   shadow_id     [HEAP_DEPTH];
    bit                          shadow_cxl    [HEAP_DEPTH];
    int                          shadow_count;

    t_result_word      pending_results [$];
    t_stim_row         directed_rows   [$];

    int                mismatches;
    int                results_seen;
    int                quiet_cycles;
    int                overflow_inserts;
    bit                receiver_held;
    t_result_word      want_word;

    always #4 i_clk = ~i_clk;

    // Moves the entry at pos down until neither child has a strictly smaller
    // expiry. On a tie between the two children the left one is taken.
    task automatic shadow_sift_down(input int start);
        int                          pos;
        int                          child;
        logic [mhtq_pkg::TIME_W-1:0] mv_expiry;
        logic [mhtq_pkg::ID_W-1:0]   mv_id;
        bit                          mv_cxl;
        pos       = start;
        mv_expiry = shadow_expiry[pos];
        mv_id     = shadow_id[pos];
        mv_cxl    = shadow_cxl[pos];
        while (pos * 2 + 1 < shadow_count) begin
            child = pos * 2 + 1;
            if (child + 1 < shadow_count && shadow_expiry[child] > shadow_expiry[child + 1])
                child++;
            if (mv_expiry > shadow_expiry[child]) begin
                shadow_expiry[pos] = shadow_expiry[child];
                shadow_id[pos]     = shadow_id[child];
                shadow_cxl[pos]    = shadow_cxl[child];
                pos = child;
            end else begin
                break;
            end
        end
        shadow_expiry[pos] = mv_expiry;
        shadow_id[pos]     = mv_id;
        shadow_cxl[pos]    = mv_cxl;
    endtask

    // Removes the root: the last entry takes its place and sinks down.
    task automatic shadow_remove_root();
        if (shadow_count > 0) begin
            shadow_count--;
            shadow_expiry[0] = shadow_expiry[shadow_count];
            shadow_id[0]     = shadow_id[shadow_count];
            shadow_cxl[0]    = shadow_cxl[shadow_count];
            if (shadow_count > 0)
                shadow_sift_down(0);
        end
    endtask

    // Applies one accepted request to the shadow heap and, when record is set,
    // queues the results that it must produce, last flag on the final one.
    task automatic timer_heap_step(input mhtq_pkg::t_action act,
                                   input logic [mhtq_pkg::ID_W-1:0] id,
                                   input logic [mhtq_pkg::TIME_W-1:0] expiry,
                                   input logic [mhtq_pkg::TIME_W-1:0] now,
                                   input bit record);
        t_result_word step_out [$];
        t_result_word word;
        int           pos;
        int           par;
        bit           found;
        word.last = 1'b0;
        case (act)
            mhtq_pkg::ACT_INSERT: begin
                if (shadow_count >= HEAP_DEPTH) begin
                    word.status = mhtq_pkg::ST_FULL;
                    word.id     = '0;
                    step_out.push_back(word);
                end else begin
                    pos = shadow_count;
                    shadow_count++;
                    while (pos > 0) begin
                        par = (pos - 1) / 2;
                        if (shadow_expiry[par] > expiry) begin
                            shadow_expiry[pos] = shadow_expiry[par];
                            shadow_id[pos]     = shadow_id[par];
                            shadow_cxl[pos]    = shadow_cxl[par];
                            pos = par;
                        end else begin
                            break;
                        end
                    end
                    shadow_expiry[pos] = expiry;
                    shadow_id[pos]     = id;
                    shadow_cxl[pos]    = 1'b0;
                    word.status = mhtq_pkg::ST_OK;
                    word.id     = '0;
                    step_out.push_back(word);
                end
            end
            mhtq_pkg::ACT_TICK: begin
                while (shadow_count > 0 && shadow_expiry[0] <= now) begin
                    if (!shadow_cxl[0]) begin
                        word.status = mhtq_pkg::ST_FIRED;
                        word.id     = shadow_id[0];
                        step_out.push_back(word);
                    end
                    shadow_remove_root();
                end
                if (step_out.size() == 0) begin
                    word.status = mhtq_pkg::ST_NONE_DUE;
                    word.id     = '0;
                    step_out.push_back(word);
                end
            end
            mhtq_pkg::ACT_CANCEL: begin
                found = 1'b0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_id[i] == id) begin
                        shadow_cxl[i] = 1'b1;
                        found = 1'b1;
                    end
                end
                word.status = found ? mhtq_pkg::ST_OK : mhtq_pkg::ST_NOT_FOUND;
                word.id     = '0;
                step_out.push_back(word);
            end
            default: begin
                if (shadow_count == 0) begin
                    word.status = mhtq_pkg::ST_EMPTY;
                    word.id     = '0;
                end else begin
                    word.status = mhtq_pkg::ST_OK;
                    word.id     = shadow_id[0];
                    shadow_remove_root();
                end
                step_out.push_back(word);
            end
        endcase
        if (record) begin
            for (int k = 0; k < step_out.size(); k++) begin
                word      = step_out[k];
                word.last = (k == step_out.size() - 1);
                pending_results.push_back(word);
            end
        end
    endtask

    task automatic add_row(input mhtq_pkg::t_action act,
                           input logic [mhtq_pkg::ID_W-1:0] id,
                           input logic [mhtq_pkg::TIME_W-1:0] expiry,
                           input logic [mhtq_pkg::TIME_W-1:0] now,
                           input bit has_want, input mhtq_pkg::t_status want_status,
                           input logic [mhtq_pkg::ID_W-1:0] want_id);
        t_stim_row row;
        row.act         = act;
        row.id          = id;
        row.expiry      = expiry;
        row.now         = now;
        row.has_want    = has_want;
        row.want_status = want_status;
        row.want_id     = want_id;
        directed_rows.push_back(row);
    endtask

    // Offers one request, starting at a falling edge, and holds it until the
    // block takes it. The shadow heap is updated at the accepting edge, so the
    // random generator always sees the state that the block will see.
    task automatic offer_request(input t_stim_row row);
        t_result_word word;
        i_valid       <= 1'b1;
        i_action      <= row.act;
        i_timer_id    <= row.id;
        i_expire_time <= row.expiry;
        i_now         <= row.now;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        timer_heap_step(row.act, row.id, row.expiry, row.now, !row.has_want);
        if (row.has_want) begin
            word.status = row.want_status;
            word.id     = row.want_id;
            word.last   = 1'b1;
            pending_results.push_back(word);
        end
        @(negedge i_clk);
    endtask

    // The sender pauses now and then between requests, except in a calm window.
    task automatic sender_gap(input bit calm);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge i_clk);
        end
    endtask

    // Expiry and current times mostly share a narrow window so that ties and
    // partial ticks are common; now and then a full-width value is used.
    function automatic logic [mhtq_pkg::TIME_W-1:0] pick_time();
        if ($urandom_range(0, 99) < 12)
            return $urandom;
        return $urandom_range(0, 2000);
    endfunction

    // Ids come from a small pool so that duplicates and cancel hits occur.
    function automatic logic [mhtq_pkg::ID_W-1:0] pick_id();
        logic [31:0] draw;
        if ($urandom_range(0, 99) < 15)
            draw = $urandom_range(0, 65535);
        else
            draw = $urandom_range(0, 31);
        return draw[mhtq_pkg::ID_W-1:0];
    endfunction

    // Builds one random request. In the fill mood most requests are inserts,
    // in the drain mood ticks and pops dominate, and the mixed mood is uniform.
    task automatic make_random_row(input int mood, output t_stim_row row);
        int          pick;
        logic [31:0] draw;
        pick = $urandom_range(0, 99);
        case (mood)
            0: begin
                draw = $urandom_range(1, 3);
                row.act = (pick < 80) ? mhtq_pkg::ACT_INSERT
                        : mhtq_pkg::t_action'(draw[mhtq_pkg::ACTION_W-1:0]);
            end
            1: begin
                if (pick < 10)      row.act = mhtq_pkg::ACT_INSERT;
                else if (pick < 50) row.act = mhtq_pkg::ACT_TICK;
                else if (pick < 80) row.act = mhtq_pkg::ACT_POP;
                else                row.act = mhtq_pkg::ACT_CANCEL;
            end
            default: begin
                draw = $urandom_range(0, 3);
                row.act = mhtq_pkg::t_action'(draw[mhtq_pkg::ACTION_W-1:0]);
            end
        endcase
        row.id     = pick_id();
        row.expiry = pick_time();
        row.now    = pick_time();
        // Most cancels name a timer that is actually stored.
        if (row.act == mhtq_pkg::ACT_CANCEL && shadow_count > 0 && $urandom_range(0, 99) < 60)
            row.id = shadow_id[$urandom_range(0, shadow_count - 1)];
        row.has_want    = 1'b0;
        row.want_status = mhtq_pkg::ST_OK;
        row.want_id     = '0;
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d: %s", results_seen, what);
    endtask

    // Result checker: every accepted result is compared with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result status %0d id %h last %b",
                                        o_status, o_result_id, o_last));
            end else begin
                want_word = pending_results.pop_front();
                if (o_status !== want_word.status)
                    note_mismatch($sformatf("status expected %0d actual %0d",
                                            want_word.status, o_status));
                if (o_result_id !== want_word.id)
                    note_mismatch($sformatf("result_id expected %h actual %h",
                                            want_word.id, o_result_id));
                if (o_last !== want_word.last)
                    note_mismatch($sformatf("last expected %b actual %b",
                                            want_word.last, o_last));
            end
            results_seen++;
        end
    end

    // Watchdog: a run that moves nothing across either channel for too long is hung.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("min_heap_timer_queue: mismatch");
                $finish;
            end
        end
    end

    // Result receiver. It stalls at random about one cycle in ten, never stalls
    // in a calm window, and once holds off for a long stretch so that the block
    // backs up and refuses new requests while the sender keeps offering.
    initial begin
        i_ready = 1'b0;
        receiver_held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!receiver_held && results_seen >= 30) begin
                receiver_held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge i_clk);
                i_ready <= 1'b1;
            end else if (results_seen >= 120 && results_seen < 260) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial begin
        t_stim_row row;
        int        mood;
        bit        filling;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = mhtq_pkg::ACT_INSERT;
        i_timer_id    = '0;
        i_expire_time = '0;
        i_now         = '0;
        mismatches       = 0;
        results_seen     = 0;
        quiet_cycles     = 0;
        overflow_inserts = 0;
        shadow_count     = 0;

        // Directed table. The store starts empty, so the first rows have
        // obvious results; the rest follow the heap model.
        add_row(mhtq_pkg::ACT_POP,    16'h0000, 32'h0000_0000, 32'h0000_0000,
                1, mhtq_pkg::ST_EMPTY,     16'h0000);
        add_row(mhtq_pkg::ACT_TICK,   16'h0000, 32'h0000_0000, 32'hFFFF_FFFF,
                1, mhtq_pkg::ST_NONE_DUE,  16'h0000);
        add_row(mhtq_pkg::ACT_CANCEL, 16'h1234, 32'h0000_0000, 32'h0000_0000,
                1, mhtq_pkg::ST_NOT_FOUND, 16'h0000);
        add_row(mhtq_pkg::ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                1, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_INSERT, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF,
                1, mhtq_pkg::ST_OK,        16'h0000);
        // Three timers with equal expiry exercise the left-child tie rule.
        add_row(mhtq_pkg::ACT_INSERT, 16'h0005, 32'd100,       32'h0000_0000,
                1, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_INSERT, 16'h0006, 32'd100,       32'h0000_0000,
                1, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_INSERT, 16'h0007, 32'd100,       32'h0000_0000,
                1, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_INSERT, 16'h0008, 32'd50,        32'h0000_0000,
                1, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_POP,    16'h0000, 32'h0000_0000, 32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_POP,    16'h0000, 32'h0000_0000, 32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);
        // Cancelling twice still reports a hit.
        add_row(mhtq_pkg::ACT_CANCEL, 16'h0006, 32'h0000_0000, 32'h0000_0000,
                1, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_CANCEL, 16'h0006, 32'h0000_0000, 32'h0000_0000,
                1, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_TICK,   16'h0000, 32'h0000_0000, 32'd99,
                1, mhtq_pkg::ST_NONE_DUE,  16'h0000);
        // Expiry equal to now fires; the cancelled timer leaves silently.
        add_row(mhtq_pkg::ACT_TICK,   16'h0000, 32'h0000_0000, 32'd100,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_INSERT, 16'h0009, 32'd200,       32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_CANCEL, 16'h0009, 32'h0000_0000, 32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);
        // Only a cancelled timer is due, so nothing fires.
        add_row(mhtq_pkg::ACT_TICK,   16'h0000, 32'h0000_0000, 32'd200,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_INSERT, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_CANCEL, 16'hFFFF, 32'h0000_0000, 32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_POP,    16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
                0, mhtq_pkg::ST_OK,        16'h0000);
        // A cancelled root is still handed out by a pop.
        add_row(mhtq_pkg::ACT_POP,    16'h0000, 32'h0000_0000, 32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_POP,    16'h0000, 32'h0000_0000, 32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);
        add_row(mhtq_pkg::ACT_TICK,   16'h0000, 32'h0000_0000, 32'h0000_0000,
                0, mhtq_pkg::ST_OK,        16'h0000);

        repeat (2)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            sender_gap(1'b0);
            offer_request(directed_rows[r]);
        end

        // Random part. It opens by filling the store and pushing a few inserts
        // past capacity, then changes mood every thirty requests.
        filling = 1'b1;
        mood    = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (filling) begin
                mood = 0;
                if (overflow_inserts >= 4)
                    filling = 1'b0;
            end else if (n % 30 == 0) begin
                mood = $urandom_range(0, 2);
            end
            make_random_row(mood, row);
            if (filling)
                row.act = mhtq_pkg::ACT_INSERT;
            if (row.act == mhtq_pkg::ACT_INSERT && shadow_count >= HEAP_DEPTH)
                overflow_inserts++;
            sender_gap(n >= 120 && n < 180);
            offer_request(row);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("min_heap_timer_queue: match");
        end else begin
            $display("min_heap_timer_queue: mismatch");
        end
        $finish;
    end

endmodule
